// ===== sv/q16_fixed_point_alu_unit_assert.svh =====
// Assertion macros shared by the Q16.16 arithmetic unit.
`ifndef Q16_FIXED_POINT_ALU_UNIT_ASSERT_SVH
`define Q16_FIXED_POINT_ALU_UNIT_ASSERT_SVH
// Same-cycle implication, checked on the rising edge of clk outside reset.
`define Q16A_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on the rising edge of clk outside reset.
`define Q16A_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`endif

// ===== sv/q16a_pkg.sv =====
// Shared types and constants of the Q16.16 arithmetic unit.
`timescale 1ns / 1ps
package q16a_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W = 32;

	localparam logic [1:0] FN_MUL = 2'd0;
	localparam logic [1:0] FN_DIV = 2'd1;
	localparam logic [1:0] FN_F2FIX = 2'd2;
	localparam logic [1:0] FN_ABS = 2'd3;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_DIV0 = 2'd1;
	localparam logic [1:0] ERR_OVF = 2'd2;

	// Single-precision field layout.
	localparam int FLT_MAN_W = 23;
	localparam int FLT_EXP_W = 8;
	localparam int FLT_BIAS = 127;

	// Data that rides alongside the divider stages.
	typedef struct packed {
		logic [1:0] func;
		logic neg;
		logic dz;
		logic [WORD_W-1:0] res;
	} side_t;
endpackage

// ===== sv/q16a_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
`timescale 1ns / 1ps
module q16a_div #(
	parameter int DW = 48
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_v,
	input logic [DW-1:0] dividend,
	input logic [q16a_pkg::WORD_W-1:0] divisor,
	input q16a_pkg::side_t side_in,
	output logic out_v,
	output logic [DW-1:0] quot,
	output q16a_pkg::side_t side_out
);
	import q16a_pkg::*;

	logic v_s [DW+1];
	logic [WORD_W-1:0] rem_s [DW+1];
	logic [DW-1:0] dq_s [DW+1];
	logic [WORD_W-1:0] dvs_s [DW+1];
	side_t side_s [DW+1];

	assign v_s[0] = in_v;
	assign rem_s[0] = '0;
	assign dq_s[0] = dividend;
	assign dvs_s[0] = divisor;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < DW; i++) begin : g_stage
		logic [WORD_W:0] part;
		logic [WORD_W:0] diff;
		logic ge;
		assign part = {rem_s[i], dq_s[i][DW-1]};
		assign diff = part - {1'b0, dvs_s[i]};
		assign ge = part >= {1'b0, dvs_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[WORD_W-1:0] : part[WORD_W-1:0];
				dq_s[i+1] <= {dq_s[i][DW-2:0], ge};
				dvs_s[i+1] <= dvs_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_v = v_s[DW];
	assign quot = dq_s[DW];
	assign side_out = side_s[DW];
endmodule

// ===== sv/q16_fixed_point_alu_unit.sv =====
// Top level of the pipelined Q16.16 fixed-point arithmetic unit.
`timescale 1ns / 1ps
// The pipeline has three front stages, one divider stage per quotient bit and one output stage.
// Throughput is one transaction per cycle while the output is not stalled; the divider's bit stages set the depth.
// A stall on the output freezes the whole pipeline, so nothing is lost or repeated.
// Reset (arst_n low, asynchronous) clears every valid bit; data registers keep their contents.
module q16_fixed_point_alu_unit #(
	parameter int FRAC_BITS = q16a_pkg::FRAC_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] func,
	input logic signed [q16a_pkg::WORD_W-1:0] a,
	input logic signed [q16a_pkg::WORD_W-1:0] b,
	output logic out_valid,
	input logic out_stall,
	output logic signed [q16a_pkg::WORD_W-1:0] result,
	output logic [1:0] error
);
	import q16a_pkg::*;

	`include "q16_fixed_point_alu_unit_assert.svh"

	// The dividend is the magnitude of a shifted left by the fraction width.
	localparam int DW = WORD_W + FRAC_BITS;
	localparam int SH_W = 10;
	localparam logic signed [SH_W-1:0] SH_OFS = SH_W'(FLT_BIAS + FLT_MAN_W - FRAC_BITS);
	localparam logic signed [SH_W-1:0] SH_MAX = SH_W'(WORD_W);
	localparam logic [DW-1:0] Q_MAX_POS = DW'({1'b0, {(WORD_W-1){1'b1}}});
	localparam logic [DW-1:0] Q_MAX_NEG = DW'({1'b1, {(WORD_W-1){1'b0}}});

	// The pipeline moves whenever the output register is free or being taken.
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// Stage 1: register the incoming transaction.
	logic v_s1;
	logic [1:0] func_s1;
	logic signed [WORD_W-1:0] a_s1, b_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s1 <= func;
			a_s1 <= a;
			b_s1 <= b;
		end
	end

	// Stage 2: product, operand magnitudes, float conversion and absolute value.
	logic [FLT_EXP_W-1:0] ex;
	logic [WORD_W-1:0] man;
	logic signed [SH_W-1:0] sh;
	logic [SH_W-1:0] sh_neg;
	logic [WORD_W-1:0] fv, f2fix;
	logic [WORD_W-1:0] ua, ub, absv;

	always_comb begin
		ex = a_s1[FLT_MAN_W +: FLT_EXP_W];
		man = WORD_W'({1'b1, a_s1[FLT_MAN_W-1:0]});
		sh = $signed({2'b00, ex}) - SH_OFS;
		sh_neg = SH_W'(-sh);
		if (ex == '0 || sh >= SH_MAX || sh <= -SH_MAX) begin
			fv = '0;
		end else if (sh >= 0) begin
			fv = man << sh[4:0];
		end else begin
			fv = man >> sh_neg[4:0];
		end
		f2fix = a_s1[WORD_W-1] ? -fv : fv;
		absv = a_s1[WORD_W-1] ? -a_s1 : a_s1;
		ua = absv;
		ub = b_s1[WORD_W-1] ? -b_s1 : b_s1;
	end

	logic v_s2;
	logic [1:0] func_s2;
	logic signed [2*WORD_W-1:0] prod_s2;
	logic [WORD_W-1:0] ua_s2, ub_s2, other_s2;
	logic neg_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			func_s2 <= func_s1;
			prod_s2 <= a_s1 * b_s1;
			ua_s2 <= ua;
			ub_s2 <= ub;
			neg_s2 <= a_s1[WORD_W-1] ^ b_s1[WORD_W-1];
			other_s2 <= (func_s1 == FN_F2FIX) ? f2fix : absv;
		end
	end

	// Stage 3: pick the non-divide result and set up the divider.
	logic v_s3;
	side_t side_s3;
	logic [WORD_W-1:0] ua_s3, ub_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3.func <= func_s2;
			side_s3.neg <= neg_s2;
			side_s3.dz <= (ub_s2 == '0);
			side_s3.res <= (func_s2 == FN_MUL) ? prod_s2[FRAC_BITS +: WORD_W] : other_s2;
			ua_s3 <= ua_s2;
			ub_s3 <= ub_s2;
		end
	end

	// Divider stages, one quotient bit each.
	logic dv_v;
	logic [DW-1:0] quot;
	side_t dv_side;

	q16a_div #(
		.DW(DW)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_v(v_s3),
		.dividend({ua_s3, {FRAC_BITS{1'b0}}}),
		.divisor(ub_s3),
		.side_in(side_s3),
		.out_v(dv_v),
		.quot(quot),
		.side_out(dv_side)
	);

	// Output stage: range check, sign and result selection.
	logic [WORD_W-1:0] res_d;
	logic [1:0] err_d;

	always_comb begin
		res_d = dv_side.res;
		err_d = ERR_NONE;
		case (dv_side.func)
			FN_DIV: begin
				if (dv_side.dz) begin
					res_d = '0;
					err_d = ERR_DIV0;
				end else if ((!dv_side.neg && quot > Q_MAX_POS) ||
					(dv_side.neg && quot > Q_MAX_NEG)) begin
					res_d = '0;
					err_d = ERR_OVF;
				end else begin
					res_d = dv_side.neg ? -quot[WORD_W-1:0] : quot[WORD_W-1:0];
				end
			end
			default: begin
				res_d = dv_side.res;
			end
		endcase
	end

	logic v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= dv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= res_d;
			error <= err_d;
		end
	end

	assign out_valid = v_s4;

	// An error result always carries a zero value.
	`Q16A_AST_IMP(a_err_zero, out_valid && error != ERR_NONE, result == '0, "error with nonzero result")
	// Only the three defined error codes ever appear.
	`Q16A_AST_IMP(a_err_code, out_valid, error == ERR_NONE || error == ERR_DIV0 || error == ERR_OVF, "bad error code")
	// A transaction held in the first stage during a stall stays put.
	`Q16A_AST_NXT(a_s1_hold, v_s1 && in_stall, v_s1 && $stable(a_s1) && $stable(func_s1), "stage 1 lost data")
endmodule

// ===== tb/tb_q16_fixed_point_alu_unit.sv =====
// Self-checking testbench for the Q16.16 fixed-point arithmetic unit.
`timescale 1ns / 1ps
module tb_q16_fixed_point_alu_unit;
	import q16a_pkg::*;

	// Directed rows: an expected result is typed in only where it is obvious.
	typedef struct {
		logic [1:0] op;
		logic [31:0] x;
		logic [31:0] y;
		bit known;
		logic [31:0] want_res;
		logic [1:0] want_err;
	} row_t;

	typedef struct {
		logic [31:0] res;
		logic [1:0] err;
	} alu_out_t;

	localparam int N_RANDOM = 2000;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] func;
	logic signed [31:0] a;
	logic signed [31:0] b;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] result;
	logic [1:0] error;

	alu_out_t pending_q[$];
	int n_errors;
	int idle_cycles;
	bit calm;
	bit stim_done;

	q16_fixed_point_alu_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .a(a), .b(b),
		.out_valid(out_valid), .out_stall(out_stall),
		.result(result), .error(error)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// The predictor follows the fixed-point definitions at the default of 16 fraction bits.
	function automatic alu_out_t compute_alu(logic [1:0] op, logic [31:0] x, logic [31:0] y);
		alu_out_t o;
		logic signed [63:0] prod;
		logic [63:0] ux;
		logic [63:0] uy;
		logic [63:0] quo;
		logic [63:0] man;
		logic [63:0] v;
		int sh;
		bit neg;
		o.err = ERR_NONE;
		o.res = '0;
		case (op)
			FN_MUL: begin
				prod = $signed(x) * $signed(y);
				o.res = 32'(prod >>> FRAC_BITS_DEF);
			end
			FN_DIV: begin
				if (y == 0) begin
					o.err = ERR_DIV0;
				end else begin
					ux = x[31] ? -{{32{1'b1}}, x} : {32'd0, x};
					uy = y[31] ? -{{32{1'b1}}, y} : {32'd0, y};
					neg = x[31] != y[31];
					quo = (ux << FRAC_BITS_DEF) / uy;
					if ((!neg && quo > 64'h7fffffff) || (neg && quo > 64'h80000000))
						o.err = ERR_OVF;
					else
						o.res = neg ? -quo[31:0] : quo[31:0];
				end
			end
			FN_F2FIX: begin
				if (x[30:23] != 0) begin
					sh = int'(x[30:23]) - FLT_BIAS - (FLT_MAN_W - FRAC_BITS_DEF);
					if (sh < 32 && sh > -32) begin
						man = {40'd0, 1'b1, x[22:0]};
						v = (sh >= 0) ? (man << sh) : (man >> (-sh));
						o.res = x[31] ? -v[31:0] : v[31:0];
					end
				end
			end
			default: begin
				o.res = x[31] ? -x : x;
			end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		n_errors++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
	endtask

	// Drive one transaction and hold it until the block takes it.
	// Valid stays high afterwards so that a following transaction can go back to back.
	task automatic send_op(logic [1:0] op, logic [31:0] x, logic [31:0] y, alu_out_t want);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		a <= x;
		b <= y;
		pending_q.push_back(want);
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [31:0] rand_float();
		logic [31:0] f;
		f = $urandom;
		// Bias exponents toward the range where the conversion is not trivially 0.
		if ($urandom_range(0, 3) != 0)
			f[30:23] = 8'($urandom_range(100, 165));
		return f;
	endfunction

	// Output side: random stall bursts, then comparison with the oldest expectation.
	initial begin
		int burst;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_q.size() == 0) begin
					report_mismatch("unexpected result", result, '0);
				end else begin
					if (result !== pending_q[0].res)
						report_mismatch("result", result, pending_q[0].res);
					if (error !== pending_q[0].err)
						report_mismatch("error", {30'd0, error}, {30'd0, pending_q[0].err});
					void'(pending_q.pop_front());
				end
			end
			if (burst > 0) begin
				burst--;
				out_stall <= burst > 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 18);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(stim_done && pending_q.size() == 0))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		row_t rows[$];
		alu_out_t want;
		logic [1:0] op;
		logic [31:0] x;
		logic [31:0] y;
		int kind;
		in_valid <= 1'b0;
		func <= FN_MUL;
		a <= '0;
		b <= '0;
		arst_n = 1'b0;
		n_errors = 0;
		calm = 1'b0;
		stim_done = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{FN_MUL, 32'h00010000, 32'h00010000, 1, 32'h00010000, ERR_NONE},
			'{FN_MUL, 32'h80000000, 32'h80000000, 0, 0, 0},
			'{FN_MUL, 32'h7fffffff, 32'h80000000, 0, 0, 0},
			'{FN_MUL, 32'hffffffff, 32'h00000001, 0, 0, 0},
			'{FN_MUL, 32'h7fffffff, 32'h7fffffff, 0, 0, 0},
			'{FN_DIV, 32'h12345678, 32'h00000000, 1, 32'h0, ERR_DIV0},
			'{FN_DIV, 32'h00000000, 32'h00000000, 1, 32'h0, ERR_DIV0},
			'{FN_DIV, 32'h80000000, 32'h00000001, 1, 32'h0, ERR_OVF},
			'{FN_DIV, 32'h7fffffff, 32'h00000001, 1, 32'h0, ERR_OVF},
			'{FN_DIV, 32'h80000000, 32'hffffffff, 1, 32'h0, ERR_OVF},
			'{FN_DIV, 32'hffff8000, 32'h00000001, 1, 32'h80000000, ERR_NONE},
			'{FN_DIV, 32'h00008000, 32'hffffffff, 0, 0, 0},
			'{FN_DIV, 32'h00030000, 32'hfffe0000, 0, 0, 0},
			'{FN_DIV, 32'h80000000, 32'h80000000, 1, 32'h00010000, ERR_NONE},
			'{FN_F2FIX, 32'h3f800000, 32'h0, 1, 32'h00010000, ERR_NONE},
			'{FN_F2FIX, 32'hbf800000, 32'h0, 1, 32'hffff0000, ERR_NONE},
			'{FN_F2FIX, 32'h007fffff, 32'h0, 1, 32'h0, ERR_NONE},
			'{FN_F2FIX, 32'h7f800000, 32'h0, 1, 32'h0, ERR_NONE},
			'{FN_F2FIX, 32'hffffffff, 32'h0, 1, 32'h0, ERR_NONE},
			'{FN_F2FIX, 32'h4f000000, 32'h0, 0, 0, 0},
			'{FN_F2FIX, 32'h33800000, 32'h0, 0, 0, 0},
			'{FN_ABS, 32'hffff0000, 32'hffffffff, 1, 32'h00010000, ERR_NONE},
			'{FN_ABS, 32'h80000000, 32'h0, 1, 32'h80000000, ERR_NONE},
			'{FN_ABS, 32'h7fffffff, 32'h0, 1, 32'h7fffffff, ERR_NONE}
		};
		foreach (rows[i]) begin
			if (rows[i].known) begin
				want.res = rows[i].want_res;
				want.err = rows[i].want_err;
			end else begin
				want = compute_alu(rows[i].op, rows[i].x, rows[i].y);
			end
			send_op(rows[i].op, rows[i].x, rows[i].y, want);
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			// Hold off once until the pipeline has drained completely.
			if (n == N_RANDOM / 2) begin
				in_valid <= 1'b0;
				wait (pending_q.size() == 0);
			end
			if (n == N_RANDOM * 7 / 8)
				calm = 1'b1;
			op = 2'($urandom_range(0, 3));
			x = $urandom;
			y = $urandom;
			kind = $urandom_range(0, 7);
			if (kind == 0)
				y = 0;
			else if (kind < 3)
				y = {{16{y[15]}}, y[15:0]};
			else if (kind == 3)
				x = {{20{x[11]}}, x[11:0]};
			if (op == FN_F2FIX)
				x = rand_float();
			send_op(op, x, y, compute_alu(op, x, y));
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;

		wait (pending_q.size() == 0);
		repeat (80) @(posedge clk);
		if (n_errors == 0 && pending_q.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
